// File: src/sis_pkg.sv
// ----------------------------------------------------------------------------
// sis_pkg: shared definitions for the sorted id set
// Field widths, command and status codes, default sizes and the cell control
// struct.
// ----------------------------------------------------------------------------
`default_nettype none

package sis_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int SIG_BITS_DEF = 64;

  localparam int KEY_W    = 16;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;
  localparam int POS_W    = 6;
  localparam int HELD_W   = 7;
  localparam int SIGOUT_W = 64;

  // request commands
  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REM  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND = 2'd2;

  // result status
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd2;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic ins;  // insert key in sorted place
    logic del;  // drop the first copy of key
  } ctl_t;

endpackage

`default_nettype wire

// File: src/sorted_id_set_with_signature.sv
// ----------------------------------------------------------------------------
// sorted_id_set_with_signature: sorted id list with a bit signature
// Ascending id list held in a row of cells; add, remove and find requests,
// each answered with status, position, entry count and signature.
// ----------------------------------------------------------------------------
//  channel | ports          | tdata (low bit up)                     | tuser
//  --------+----------------+----------------------------------------+--------
//  in      | in_t*          | key[15:0]                              | command
//  out     | out_t*         | position, entries_held, signature, pad | status
//
//  add: the execute state finishes the request and loads the result register
//  when it is free; remove: the execute state repeats, one shift of the cell row
//  per copy dropped, until no copy is left; find: the execute state, then binary
//  search steps over the registered match range.
//  one request is worked at a time; a finished result sits in the output
//  register while the next request is accepted.
//  reset empties the list and clears the signature, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_id_set_with_signature #(
  parameter int CAPACITY = sis_pkg::CAPACITY_DEF,
  parameter int SIG_BITS = sis_pkg::SIG_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // key[15:0]
  input  wire  [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [79:0] out_tdata,  // position[5:0], entries_held[12:6],
                                  // signature[76:13], zero pad[79:77]
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int RW = $clog2(SIG_BITS);
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SRCH = 2'd2;
  localparam logic [1:0] ST_WAIT = 2'd3;

  // ---------------- residue of key mod SIG_BITS via nibble tables
  logic [RW-1:0] nib_tab [4][16];
  logic [RW-1:0] mod_tab [256];
  logic [7:0]    res_sum;
  logic [RW-1:0] in_res;

  for (genvar k = 0; k < 4; k++) begin : g_nib
    for (genvar n = 0; n < 16; n++) begin : g_ent
      localparam int V = (n * (1 << (4 * k))) % SIG_BITS;
      assign nib_tab[k][n] = RW'(V);
    end
  end

  for (genvar g = 0; g < 256; g++) begin : g_mod
    localparam int M = g % SIG_BITS;
    assign mod_tab[g] = RW'(M);
  end

  assign res_sum = 8'(nib_tab[0][in_tdata[3:0]]) + 8'(nib_tab[1][in_tdata[7:4]])
                 + 8'(nib_tab[2][in_tdata[11:8]]) + 8'(nib_tab[3][in_tdata[15:12]]);
  assign in_res  = mod_tab[res_sum];

  // ---------------- registers
  logic [1:0]                  state_r, state_nxt;
  logic [sis_pkg::CMD_W-1:0]   cmd_r;
  logic [sis_pkg::KEY_W-1:0]   key_r;
  logic [RW-1:0]               res_r;
  logic                        hit_r, hit_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [SIG_BITS-1:0]         sig_r, sig_nxt;
  logic [CW-1:0]               lo_r, lo_nxt;
  logic [CW-1:0]               hp1_r, hp1_nxt;
  logic [IW-1:0]               f_r, f_nxt;
  logic [IW-1:0]               l_r, l_nxt;
  logic [sis_pkg::STAT_W-1:0]  pend_stat_r, pend_stat_nxt;
  logic [IW-1:0]               pend_pos_r, pend_pos_nxt;
  logic                        out_valid_r;
  logic [sis_pkg::STAT_W-1:0]  out_stat_r;
  logic [IW-1:0]               out_pos_r;
  logic [CW-1:0]               out_count_r;
  logic [SIG_BITS-1:0]         out_sig_r;

  // ---------------- cell row
  sis_pkg::ctl_t  ctl;
  logic           any_eq;
  logic [IW-1:0]  first_idx, last_idx;
  logic [SIG_BITS-1:0] row_sig;

  sis_chain #(
    .CAPACITY (CAPACITY),
    .SIG_BITS (SIG_BITS),
    .RW       (RW),
    .IW       (IW)
  ) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .key       (key_r),
    .res       (res_r),
    .any_eq    (any_eq),
    .first_idx (first_idx),
    .last_idx  (last_idx),
    .sig       (row_sig)
  );

  // ---------------- control
  logic                       accept;
  logic                       out_free;
  logic                       full;
  logic                       fin;
  logic [sis_pkg::STAT_W-1:0] fin_stat;
  logic [IW-1:0]              fin_pos;
  logic [CW:0]                mid_sum;
  logic [CW-1:0]              mid;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign full      = (count_r == CW'(CAPACITY));
  // floor((lo + hi) / 2) with hi kept as hi + 1
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hp1_r} - (CW + 1)'(1);
  assign mid       = mid_sum[CW:1];

  always_comb begin
    state_nxt     = state_r;
    hit_nxt       = hit_r;
    count_nxt     = count_r;
    sig_nxt       = sig_r;
    lo_nxt        = lo_r;
    hp1_nxt       = hp1_r;
    f_nxt         = f_r;
    l_nxt         = l_r;
    pend_stat_nxt = pend_stat_r;
    pend_pos_nxt  = pend_pos_r;
    ctl           = '0;
    fin           = 1'b0;
    fin_stat      = sis_pkg::STAT_OK;
    fin_pos       = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          hit_nxt   = 1'b0;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (cmd_r)
          sis_pkg::CMD_ADD: begin
            fin = 1'b1;
            if (full) begin
              fin_stat = sis_pkg::STAT_FULL;
            end else begin
              ctl.ins   = 1'b1;
              count_nxt = count_r + CW'(1);
              sig_nxt   = sig_r | (SIG_BITS'(1) << res_r);
            end
          end
          sis_pkg::CMD_REM: begin
            if (any_eq) begin
              // one copy per cycle until none is left
              ctl.del   = 1'b1;
              count_nxt = count_r - CW'(1);
              hit_nxt   = 1'b1;
            end else begin
              fin = 1'b1;
              if (hit_r) begin
                sig_nxt = row_sig;
              end else begin
                fin_stat = sis_pkg::STAT_MISS;
              end
            end
          end
          sis_pkg::CMD_FIND: begin
            if (any_eq) begin
              f_nxt     = first_idx;
              l_nxt     = last_idx;
              lo_nxt    = '0;
              hp1_nxt   = count_r;
              state_nxt = ST_SRCH;
            end else begin
              fin      = 1'b1;
              fin_stat = sis_pkg::STAT_MISS;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      ST_SRCH: begin
        if (mid < CW'(f_r)) begin
          lo_nxt = mid + CW'(1);
        end else if (mid > CW'(l_r)) begin
          hp1_nxt = mid;
        end else begin
          fin     = 1'b1;
          fin_pos = IW'(mid);
        end
      end
      ST_WAIT: begin
        fin      = 1'b1;
        fin_stat = pend_stat_r;
        fin_pos  = pend_pos_r;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fin) begin
      if (out_free) begin
        state_nxt = ST_IDLE;
      end else begin
        pend_stat_nxt = fin_stat;
        pend_pos_nxt  = fin_pos;
        state_nxt     = ST_WAIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hit_r       <= 1'b0;
      count_r     <= '0;
      sig_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hit_r   <= hit_nxt;
      count_r <= count_nxt;
      sig_r   <= sig_nxt;
      if (fin && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_tuser;
      key_r <= in_tdata;
      res_r <= in_res;
    end
    lo_r        <= lo_nxt;
    hp1_r       <= hp1_nxt;
    f_r         <= f_nxt;
    l_r         <= l_nxt;
    pend_stat_r <= pend_stat_nxt;
    pend_pos_r  <= pend_pos_nxt;
    if (fin && out_free) begin
      out_stat_r  <= fin_stat;
      out_pos_r   <= fin_pos;
      out_count_r <= count_nxt;
      out_sig_r   <= sig_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {3'b000,
                       sis_pkg::SIGOUT_W'(out_sig_r),
                       sis_pkg::HELD_W'(out_count_r),
                       sis_pkg::POS_W'(out_pos_r)};

endmodule

`default_nettype wire

// File: src/sis_cell.sv
// ----------------------------------------------------------------------------
// sis_cell: one slot of the sorted id row
// Holds one id with its signature residue and a valid bit, compares it with
// the broadcast key and trades contents with its neighbors on insert/delete.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_cell #(
  parameter int RW = 6,
  parameter int SB = 64
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  sis_pkg::ctl_t              ctl,
  input  wire [sis_pkg::KEY_W-1:0]   key,
  input  wire [RW-1:0]               res,
  input  wire [sis_pkg::KEY_W-1:0]   lf_id,
  input  wire [RW-1:0]               lf_res,
  input  wire                        lf_valid,
  input  wire                        lf_s,
  input  wire                        lf_eq,
  input  wire [sis_pkg::KEY_W-1:0]   rt_id,
  input  wire [RW-1:0]               rt_res,
  input  wire                        rt_valid,
  input  wire                        rt_eq,
  output logic [sis_pkg::KEY_W-1:0]  id_o,
  output logic [RW-1:0]              res_o,
  output logic                       valid_o,
  output logic                       s_o,
  output logic                       eq_o,
  output logic                       first_o,
  output logic                       last_o,
  output logic [SB-1:0]              sig_o
);

  logic [sis_pkg::KEY_W-1:0] id_r, id_nxt;
  logic [RW-1:0]             res_r, res_nxt;
  logic                      valid_r, valid_nxt;
  logic                      ge;

  assign ge      = valid_r && (id_r >= key);
  assign eq_o    = valid_r && (id_r == key);
  // empty slot or id above key: insertion point is at or before here
  assign s_o     = !valid_r || (id_r > key);
  assign first_o = eq_o && !lf_eq;
  assign last_o  = eq_o && !rt_eq;
  assign id_o    = id_r;
  assign res_o   = res_r;
  assign valid_o = valid_r;
  assign sig_o   = valid_r ? (SB'(1) << res_r) : '0;

  always_comb begin
    id_nxt    = id_r;
    res_nxt   = res_r;
    valid_nxt = valid_r;
    if (ctl.ins) begin
      valid_nxt = valid_r || lf_valid;
      if (lf_s) begin
        id_nxt  = lf_id;
        res_nxt = lf_res;
      end else if (s_o) begin
        id_nxt  = key;
        res_nxt = res;
      end
    end else if (ctl.del) begin
      // from the first match on, everything moves one slot left
      if (ge) begin
        id_nxt    = rt_id;
        res_nxt   = rt_res;
        valid_nxt = rt_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    res_r <= res_nxt;
  end

endmodule

`default_nettype wire

// File: src/sis_chain.sv
// ----------------------------------------------------------------------------
// sis_chain: row of id cells
// Links the cells to their neighbors and reduces their flags to a match
// indicator, the first/last match index and the signature.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_chain #(
  parameter int CAPACITY = sis_pkg::CAPACITY_DEF,
  parameter int SIG_BITS = sis_pkg::SIG_BITS_DEF,
  parameter int RW       = $clog2(SIG_BITS),
  parameter int IW       = $clog2(CAPACITY)
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  sis_pkg::ctl_t             ctl,
  input  wire [sis_pkg::KEY_W-1:0]  key,
  input  wire [RW-1:0]              res,
  output logic                      any_eq,
  output logic [IW-1:0]             first_idx,
  output logic [IW-1:0]             last_idx,
  output logic [SIG_BITS-1:0]       sig
);

  logic [sis_pkg::KEY_W-1:0] id_w    [CAPACITY];
  logic [RW-1:0]             res_w   [CAPACITY];
  logic                      valid_w [CAPACITY];
  logic                      s_w     [CAPACITY];
  logic                      eq_w    [CAPACITY];
  logic                      first_w [CAPACITY];
  logic                      last_w  [CAPACITY];
  logic [SIG_BITS-1:0]       sig_w   [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [sis_pkg::KEY_W-1:0] lf_id, rt_id;
    logic [RW-1:0]             lf_res, rt_res;
    logic                      lf_valid, lf_s, lf_eq, rt_valid, rt_eq;

    if (i == 0) begin : g_head
      assign lf_id    = '0;
      assign lf_res   = '0;
      assign lf_valid = 1'b1;
      assign lf_s     = 1'b0;
      assign lf_eq    = 1'b0;
    end else begin : g_mid_l
      assign lf_id    = id_w[i-1];
      assign lf_res   = res_w[i-1];
      assign lf_valid = valid_w[i-1];
      assign lf_s     = s_w[i-1];
      assign lf_eq    = eq_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign rt_id    = '0;
      assign rt_res   = '0;
      assign rt_valid = 1'b0;
      assign rt_eq    = 1'b0;
    end else begin : g_mid_r
      assign rt_id    = id_w[i+1];
      assign rt_res   = res_w[i+1];
      assign rt_valid = valid_w[i+1];
      assign rt_eq    = eq_w[i+1];
    end

    sis_cell #(
      .RW (RW),
      .SB (SIG_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .key      (key),
      .res      (res),
      .lf_id    (lf_id),
      .lf_res   (lf_res),
      .lf_valid (lf_valid),
      .lf_s     (lf_s),
      .lf_eq    (lf_eq),
      .rt_id    (rt_id),
      .rt_res   (rt_res),
      .rt_valid (rt_valid),
      .rt_eq    (rt_eq),
      .id_o     (id_w[i]),
      .res_o    (res_w[i]),
      .valid_o  (valid_w[i]),
      .s_o      (s_w[i]),
      .eq_o     (eq_w[i]),
      .first_o  (first_w[i]),
      .last_o   (last_w[i]),
      .sig_o    (sig_w[i])
    );
  end

  // matches are contiguous, so first/last flags are one-hot
  always_comb begin
    any_eq    = 1'b0;
    first_idx = '0;
    last_idx  = '0;
    sig       = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      any_eq = any_eq | eq_w[i];
      if (first_w[i]) begin
        first_idx = first_idx | IW'(i);
      end
      if (last_w[i]) begin
        last_idx = last_idx | IW'(i);
      end
      sig = sig | sig_w[i];
    end
  end

endmodule

`default_nettype wire

// File: tb/sorted_id_set_with_signature_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_id_set_with_signature_test: self-checking bench for the sorted id set
// A short table of add, remove, find and unused-command requests, the first
// seven with typed answers, then segments of random requests that cycle through
// fill, mixed and drain modes, using narrow key pools for duplicates and hits.
// Every answer is compared field by field with its typed answer or a model of the list.
// ----------------------------------------------------------------------------

module sorted_id_set_with_signature_test;

  localparam int                        HELD_MAX     = sis_pkg::CAPACITY_DEF;
  localparam logic [sis_pkg::CMD_W-1:0] CMD_NOP      = 2'd3;
  localparam int                        RANDOM_ITEMS = 750;
  localparam int                        STEADY_TAIL  = 120;
  localparam int                        STALL_LIMIT  = 4000;
  localparam int                        DRAIN_CYCLES = 100;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} edit_mode_t;

  typedef struct packed {
    logic [sis_pkg::STAT_W-1:0]   status;
    logic [sis_pkg::POS_W-1:0]    position;
    logic [sis_pkg::HELD_W-1:0]   held;
    logic [sis_pkg::SIGOUT_W-1:0] signature;
  } answer_t;

  typedef struct {
    logic [sis_pkg::CMD_W-1:0] cmd;
    logic [sis_pkg::KEY_W-1:0] key;
    bit                        typed;
    answer_t                   ans;
  } request_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [1:0]  out_tuser;

  sorted_id_set_with_signature uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // model of the list
  logic [sis_pkg::KEY_W-1:0]    held_ids [0:HELD_MAX-1];
  int                           held_count = 0;
  logic [sis_pkg::SIGOUT_W-1:0] held_sig = '0;

  answer_t      answers_due [$];
  request_row_t known_rows [$];
  int           mismatches = 0;
  bit           steady = 1'b0;
  int           stall_left = 0;
  int           quiet_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void rebuild_signature();
    held_sig = '0;
    for (int i = 0; i < held_count; i++) held_sig[held_ids[i][5:0]] = 1'b1;
  endfunction

  // applies one request to the model list and returns its answer
  function automatic answer_t serve(logic [sis_pkg::CMD_W-1:0] cmd,
                                    logic [sis_pkg::KEY_W-1:0] key);
    answer_t a;
    int      j;
    int      k;
    int      lo;
    int      hi;
    int      mid;
    a = '0;
    case (cmd)
      sis_pkg::CMD_ADD: begin
        if (held_count >= HELD_MAX) begin
          a.status = sis_pkg::STAT_FULL;
        end else begin
          j = held_count;
          while (j > 0 && held_ids[j-1] > key) begin
            held_ids[j] = held_ids[j-1];
            j--;
          end
          held_ids[j] = key;
          held_count++;
          rebuild_signature();
        end
      end
      sis_pkg::CMD_REM: begin
        k = 0;
        for (int i = 0; i < held_count; i++) begin
          if (held_ids[i] != key) begin
            held_ids[k] = held_ids[i];
            k++;
          end
        end
        if (k == held_count) begin
          a.status = sis_pkg::STAT_MISS;
        end else begin
          held_count = k;
          rebuild_signature();
        end
      end
      sis_pkg::CMD_FIND: begin
        a.status = sis_pkg::STAT_MISS;
        lo = 0;
        hi = held_count - 1;
        while (lo <= hi) begin
          mid = lo + (hi - lo) / 2;
          if (held_ids[mid] == key) begin
            a.status   = sis_pkg::STAT_OK;
            a.position = mid[sis_pkg::POS_W-1:0];
            break;
          end else if (held_ids[mid] < key) begin
            lo = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
      end
      default: ;
    endcase
    a.held      = held_count[sis_pkg::HELD_W-1:0];
    a.signature = held_sig;
    return a;
  endfunction

  task automatic plan(logic [sis_pkg::CMD_W-1:0] cmd, logic [sis_pkg::KEY_W-1:0] key,
                      bit typed, logic [sis_pkg::STAT_W-1:0] status, int position,
                      int held, logic [sis_pkg::SIGOUT_W-1:0] signature);
    request_row_t r;
    r.cmd = cmd;
    r.key = key;
    r.typed = typed;
    r.ans.status = status;
    r.ans.position = position[sis_pkg::POS_W-1:0];
    r.ans.held = held[sis_pkg::HELD_W-1:0];
    r.ans.signature = signature;
    known_rows.push_back(r);
  endtask

  // offers one request, optionally after an idle burst, and books its answer
  task automatic send(logic [sis_pkg::CMD_W-1:0] cmd, logic [sis_pkg::KEY_W-1:0] key,
                      bit typed, answer_t typed_ans);
    answer_t a;
    int      gap;
    if (!steady && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= key;
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    a = serve(cmd, key);
    answers_due.push_back(typed ? typed_ans : a);
  endtask

  task automatic wait_all_answered();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [sis_pkg::KEY_W-1:0] pick_key(bit narrow,
                                                         logic [sis_pkg::KEY_W-1:0] base);
    if (held_count > 0 && $urandom_range(0, 9) < 4)
      return held_ids[$urandom_range(0, held_count - 1)];
    if (narrow)
      return base + sis_pkg::KEY_W'($urandom_range(0, 7));
    return sis_pkg::KEY_W'($urandom);
  endfunction

  function automatic logic [sis_pkg::CMD_W-1:0] pick_cmd(edit_mode_t mode);
    int roll;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  return roll < 80 ? sis_pkg::CMD_ADD : roll < 88 ? sis_pkg::CMD_REM :
                         roll < 98 ? sis_pkg::CMD_FIND : CMD_NOP;
      MODE_DRAIN: return roll < 20 ? sis_pkg::CMD_ADD : roll < 75 ? sis_pkg::CMD_REM :
                         roll < 95 ? sis_pkg::CMD_FIND : CMD_NOP;
      default:    return roll < 40 ? sis_pkg::CMD_ADD : roll < 65 ? sis_pkg::CMD_REM :
                         roll < 95 ? sis_pkg::CMD_FIND : CMD_NOP;
    endcase
  endfunction

  // result side: random stall bursts, none once steady
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (rst_n && !steady && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      out_tready <= rst_n;
    end
  end

  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (answers_due.size() == 0) begin
        $error("answer with no request outstanding: tdata %h tuser %h", out_tdata, out_tuser);
        mismatches++;
      end else begin
        e = answers_due.pop_front();
        if (out_tuser !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_tuser);
          mismatches++;
        end
        if (out_tdata[5:0] !== e.position) begin
          $error("position: expected %0d, got %0d", e.position, out_tdata[5:0]);
          mismatches++;
        end
        if (out_tdata[12:6] !== e.held) begin
          $error("entries_held: expected %0d, got %0d", e.held, out_tdata[12:6]);
          mismatches++;
        end
        if (out_tdata[76:13] !== e.signature) begin
          $error("signature: expected %h, got %h", e.signature, out_tdata[76:13]);
          mismatches++;
        end
        if (out_tdata[79:77] !== 3'b000) begin
          $error("pad: expected 0, got %0d", out_tdata[79:77]);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("sorted_id_set_with_signature_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    edit_mode_t                mode;
    bit                        narrow;
    logic [sis_pkg::KEY_W-1:0] base;
    int                        sent;
    int                        seg;
    int                        seg_len;

    // rows with a typed answer start from an empty list
    plan(sis_pkg::CMD_FIND, 16'h1234, 1, sis_pkg::STAT_MISS, 0, 0, 64'h0);
    plan(sis_pkg::CMD_REM,  16'h1234, 1, sis_pkg::STAT_MISS, 0, 0, 64'h0);
    plan(CMD_NOP,           16'hFFFF, 1, sis_pkg::STAT_OK,   0, 0, 64'h0);
    plan(sis_pkg::CMD_ADD,  16'h0000, 1, sis_pkg::STAT_OK,   0, 1, 64'h1);
    plan(sis_pkg::CMD_ADD,  16'hFFFF, 1, sis_pkg::STAT_OK,   0, 2, 64'h8000_0000_0000_0001);
    plan(sis_pkg::CMD_FIND, 16'h0000, 1, sis_pkg::STAT_OK,   0, 2, 64'h8000_0000_0000_0001);
    plan(sis_pkg::CMD_FIND, 16'hFFFF, 1, sis_pkg::STAT_OK,   1, 2, 64'h8000_0000_0000_0001);
    // duplicates and ids that share a signature bit
    plan(sis_pkg::CMD_ADD,  16'h0040, 0, sis_pkg::STAT_OK, 0, 0, '0);
    plan(sis_pkg::CMD_ADD,  16'h0040, 0, sis_pkg::STAT_OK, 0, 0, '0);
    plan(sis_pkg::CMD_ADD,  16'h0040, 0, sis_pkg::STAT_OK, 0, 0, '0);
    plan(sis_pkg::CMD_ADD,  16'h8001, 0, sis_pkg::STAT_OK, 0, 0, '0);
    plan(sis_pkg::CMD_FIND, 16'h0040, 0, sis_pkg::STAT_OK, 0, 0, '0);
    plan(sis_pkg::CMD_REM,  16'h0040, 0, sis_pkg::STAT_OK, 0, 0, '0);
    plan(sis_pkg::CMD_FIND, 16'h0040, 0, sis_pkg::STAT_OK, 0, 0, '0);
    plan(sis_pkg::CMD_ADD,  16'h5555, 0, sis_pkg::STAT_OK, 0, 0, '0);
    plan(sis_pkg::CMD_ADD,  16'hAAAA, 0, sis_pkg::STAT_OK, 0, 0, '0);
    plan(CMD_NOP,           16'h5555, 0, sis_pkg::STAT_OK, 0, 0, '0);
    plan(sis_pkg::CMD_REM,  16'h0000, 0, sis_pkg::STAT_OK, 0, 0, '0);
    plan(sis_pkg::CMD_REM,  16'hFFFF, 0, sis_pkg::STAT_OK, 0, 0, '0);
    plan(sis_pkg::CMD_FIND, 16'h8001, 0, sis_pkg::STAT_OK, 0, 0, '0);
    plan(sis_pkg::CMD_REM,  16'h7777, 0, sis_pkg::STAT_OK, 0, 0, '0);
    plan(sis_pkg::CMD_ADD,  16'h0001, 0, sis_pkg::STAT_OK, 0, 0, '0);
    plan(sis_pkg::CMD_FIND, 16'h0002, 0, sis_pkg::STAT_OK, 0, 0, '0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (known_rows[i])
      send(known_rows[i].cmd, known_rows[i].key, known_rows[i].typed, known_rows[i].ans);
    wait_all_answered();

    // fill, drain and mixed segments; the first one pushes the list to full
    sent = 0;
    seg = 0;
    while (sent < RANDOM_ITEMS) begin
      mode = (seg % 3 == 0) ? MODE_FILL : (seg % 3 == 1) ? MODE_MIXED : MODE_DRAIN;
      narrow = (seg == 0) ? 1'b1 : 1'($urandom_range(0, 1));
      base = sis_pkg::KEY_W'($urandom_range(0, 16'hFFF8));
      seg_len = (mode == MODE_FILL) ? $urandom_range(90, 120) : $urandom_range(60, 100);
      for (int n = 0; n < seg_len && sent < RANDOM_ITEMS; n++) begin
        steady = (sent >= RANDOM_ITEMS - STEADY_TAIL);
        send(pick_cmd(mode), pick_key(narrow, base), 1'b0, '0);
        sent++;
      end
      if ($urandom_range(0, 1) == 0) wait_all_answered();
      seg++;
    end

    wait_all_answered();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("sorted_id_set_with_signature_test OK");
    end else begin
      $display("sorted_id_set_with_signature_test NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
src/sis_pkg.sv
src/sis_cell.sv
src/sis_chain.sv
src/sorted_id_set_with_signature.sv
tb/sorted_id_set_with_signature_test.sv
